// ===== rtl/sha1sh_pkg.sv =====
// Shared types and constants for the streaming SHA-1 hasher.
// No dependencies; every other file imports this package.
package sha1sh_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
		logic        length_overflow;
	} out_item_t;

	// Command passed from the front end to the compression engine.
	typedef struct packed {
		logic [511:0] block;
		logic         finish;
		logic         overflow;
	} job_t;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam int          WORD_COUNT = 5;

endpackage

// ===== rtl/sha1sh_front.sv =====
// Front end: gathers bytes into blocks, counts bits, builds padding blocks.
// Depends on sha1sh_pkg.
module sha1sh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1sh_pkg::in_item_t in_item,
	input  logic                 push,
	output logic                 full,
	output sha1sh_pkg::job_t     job,
	output logic                 job_valid,
	input  logic                 job_ready
);
	import sha1sh_pkg::*;

	localparam logic [1:0] ST_COLLECT = 2'd0;
	localparam logic [1:0] ST_PAD2    = 2'd1;

	logic [1:0]   state_q;
	logic [511:0] blk_q;
	logic [6:0]   fill_q;
	logic [63:0]  bits_q;
	logic         ovf_q;
	logic         job_valid_q;
	job_t         job_q;
	logic [511:0] cur_block;
	logic [511:0] pad_block;
	logic [511:0] len_block;
	logic         accept;
	logic [63:0]  bits_next;
	logic         store;

	assign full = job_valid_q || (state_q != ST_COLLECT);
	assign accept = push && !full;
	assign store = in_item.has_byte && !ovf_q;
	assign bits_next = bits_q + 64'd8;
	assign job = job_q;
	assign job_valid = job_valid_q;

	// Block as it stands, with the new byte (if stored) included; bytes past the fill
	// become zero, and in pad_block the pad byte sits right after the last data byte.
	always_comb begin
		logic [6:0] n;
		n = fill_q + {6'd0, accept && store};
		for (int i = 0; i < 64; i++) begin
			logic [7:0] b;
			if (accept && store && (i == int'(fill_q[5:0])))
				b = in_item.data_byte;
			else
				b = blk_q[511-8*i -: 8];
			cur_block[511-8*i -: 8] = (i < int'(n)) ? b : 8'd0;
			pad_block[511-8*i -: 8] = (i < int'(n)) ? b : ((i == int'(n)) ? PAD_BYTE : 8'd0);
			len_block[511-8*i -: 8] = 8'd0;
		end
		if (n < 7'd56)
			pad_block[63:0] = store && accept ? bits_next : bits_q;
		len_block[63:0] = bits_q;
	end

	// Byte 0 of the block sits in the top bits.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 64; i++)
			if (accept && store && (fill_q[5:0] == 6'(i)))
				blk_q[511-8*i -: 8] <= in_item.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			fill_q <= '0;
			bits_q <= '0;
			ovf_q <= 1'b0;
			job_valid_q <= 1'b0;
			job_q <= '0;
		end else begin
			if (job_valid_q && job_ready && (state_q != ST_PAD2))
				job_valid_q <= 1'b0;
			case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						logic [6:0] n;
						logic       o;
						n = fill_q + {6'd0, store};
						o = ovf_q || (store && (bits_next == 64'd0));
						if (in_item.end_of_message && o) begin
							job_q <= '{block: '0, finish: 1'b1, overflow: 1'b1};
							job_valid_q <= 1'b1;
							fill_q <= '0; bits_q <= '0; ovf_q <= 1'b0;
						end else if (in_item.end_of_message && (n >= 7'd56)) begin
							job_q <= '{block: (n == 7'd64) ? cur_block : pad_block,
								finish: 1'b0, overflow: 1'b0};
							job_valid_q <= 1'b1;
							state_q <= ST_PAD2;
							if (store) bits_q <= bits_next;
							fill_q <= n;
							ovf_q <= o;
						end else if (in_item.end_of_message) begin
							job_q <= '{block: pad_block, finish: 1'b1, overflow: 1'b0};
							job_valid_q <= 1'b1;
							fill_q <= '0; bits_q <= '0; ovf_q <= 1'b0;
						end else begin
							if (store) bits_q <= bits_next;
							ovf_q <= o;
							if (n == 7'd64) begin
								job_q <= '{block: cur_block, finish: 1'b0, overflow: 1'b0};
								job_valid_q <= 1'b1;
								fill_q <= '0;
							end else if (store) begin
								fill_q <= n;
							end
						end
					end
				end
				ST_PAD2: begin
					if (!job_valid_q || job_ready) begin
						// Full block ended exactly: second block carries the pad byte too.
						job_q <= '{block: (fill_q == 7'd64) ? {PAD_BYTE, len_block[503:0]}
							: len_block, finish: 1'b1, overflow: 1'b0};
						job_valid_q <= 1'b1;
						state_q <= ST_COLLECT;
						fill_q <= '0; bits_q <= '0; ovf_q <= 1'b0;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q && !job_ready |=> job_valid_q && $stable(job_q)) else $error("job dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 7'd64) else $error("fill beyond block");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD2 |-> full) else $error("accept during pad");
endmodule

// ===== rtl/sha1sh_core.sv =====
// Compression engine: 80 rounds, one per cycle, then digest word output queue.
// Depends on sha1sh_pkg.
module sha1sh_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1sh_pkg::job_t      job,
	input  logic                  job_valid,
	output logic                  job_ready,
	output sha1sh_pkg::out_item_t out_item,
	output logic                  empty,
	input  logic                  pop
);
	import sha1sh_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]  state_q;
	logic [6:0]  rnd_q;
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] h_q [5];
	logic        fin_q;
	logic        ovf_q;
	logic [2:0]  word_q;
	logic [31:0] f, k, t, wnext;

	assign job_ready = (state_q == ST_IDLE);
	assign empty = (state_q != ST_EMIT);
	assign out_item.digest_word = ovf_q ? 32'd0 : h_q[word_q];
	assign out_item.word_number = word_q;
	assign out_item.last_word = ovf_q || (word_q == 3'(WORD_COUNT - 1));
	assign out_item.length_overflow = ovf_q;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + w_q[0] + k;
		wnext = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			word_q <= '0;
			fin_q <= 1'b0;
			ovf_q <= 1'b0;
			h_q <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						fin_q <= job.finish;
						ovf_q <= job.overflow;
						word_q <= '0;
						rnd_q <= '0;
						if (job.overflow) begin
							state_q <= ST_EMIT;
						end else begin
							for (int i = 0; i < 16; i++)
								w_q[i] <= job.block[511-32*i -: 32];
							a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
							d_q <= h_q[3]; e_q <= h_q[4];
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++)
						w_q[i] <= w_q[i+1];
					w_q[15] <= {wnext[30:0], wnext[31]};
					a_q <= t; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]};
					d_q <= c_q; e_q <= d_q;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) begin
						h_q[0] <= h_q[0] + t;
						h_q[1] <= h_q[1] + a_q;
						h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
						h_q[3] <= h_q[3] + c_q;
						h_q[4] <= h_q[4] + d_q;
						state_q <= fin_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (pop) begin
						word_q <= word_q + 3'd1;
						if (out_item.last_word) begin
							state_q <= ST_IDLE;
							ovf_q <= 1'b0;
							h_q <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> word_q <= 3'(WORD_COUNT - 1)) else $error("word index");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> rnd_q < 7'd80) else $error("round count");
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !empty |-> word_q == 3'd0) else $error("overflow result count");
endmodule

// ===== rtl/sha1_stream_hasher_top.sv =====
// Top level of the streaming SHA-1 hasher.
// Depends on sha1sh_pkg, sha1sh_front and sha1sh_core.
//
// The hasher takes one message byte per transfer (or an end marker without a byte, so
// empty messages work), hashes each full 64-byte block with an 80-round engine that runs
// one round per cycle, and on the end marker pads the message and delivers the five
// digest words H0..H4 as five result transfers, or a single result with length_overflow
// set if the bit count passed 2^64. Bytes take one cycle each while the front end
// gathers a block and no finished block waits; a finished block waits in a one-entry
// hand-off register until the engine takes it, and the next block gathers while the
// rounds run, so the sustained rate is set by the round engine. A message end costs one or
// two extra blocks of rounds. Bytes of the next message are gathered meanwhile, but its
// first full block waits until the digest words have all been popped.
module sha1_stream_hasher_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha1sh_pkg::in_item_t   in_item,
	input  logic                   push,
	output logic                   full,
	output sha1sh_pkg::out_item_t  out_item,
	output logic                   empty,
	input  logic                   pop
);
	import sha1sh_pkg::*;

	job_t job;
	logic job_valid;
	logic job_ready;

	sha1sh_front u_front (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .push(push), .full(full),
		.job(job), .job_valid(job_valid), .job_ready(job_ready)
	);

	sha1sh_core u_core (
		.clk(clk), .arst_n(arst_n), .job(job), .job_valid(job_valid),
		.job_ready(job_ready), .out_item(out_item), .empty(empty), .pop(pop)
	);
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming SHA-1 hasher.
// Depends on sha1sh_pkg and sha1_stream_hasher_top; it needs no other file.
// A local SHA-1 model predicts every digest result, and the results are checked in order.
module testbench;
	import sha1sh_pkg::*;

	localparam int STALL_LIMIT = 4000;   // cycles with no transfer before we give up
	localparam int DRAIN_CYCLES = 200;   // two blocks of rounds plus margin

	logic      clk;
	logic      arst_n;
	in_item_t  in_item;
	logic      push;
	logic      full;
	out_item_t out_item;
	logic      empty;
	logic      pop;

	sha1_stream_hasher_top uut (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .push(push), .full(full),
		.out_item(out_item), .empty(empty), .pop(pop)
	);

	// Idle percentages for the sender and the receiver; the test sequence changes them.
	int snd_idle_pct;
	int rcv_idle_pct;
	int error_count;
	int items_sent;
	int stall_cycles;

	// Predicted digest words, oldest first.
	out_item_t digest_queue[$];

	// Local copy of the hashing state.
	logic [7:0]  msg_block[64];
	int          fill_count;
	logic [63:0] msg_bits;
	logic [31:0] chain[5];
	logic        len_overflow;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [31:0] rol(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void restart_hash();
		fill_count = 0;
		msg_bits = '0;
		chain[0] = H0_INIT; chain[1] = H1_INIT; chain[2] = H2_INIT;
		chain[3] = H3_INIT; chain[4] = H4_INIT;
		len_overflow = 1'b0;
	endfunction

	// One 80-round compression of msg_block into the chaining value.
	function automatic void compress_block();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			t = rol(a, 5) + f + e + w[i] + k;
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
		fill_count = 0;
	endfunction

	// Works out the results of one accepted item and queues them.
	function automatic void predict_digest(in_item_t it);
		out_item_t r;
		if (it.has_byte && !len_overflow) begin
			msg_block[fill_count] = it.data_byte;
			fill_count++;
			msg_bits += 64'd8;
			if (msg_bits == 0)
				len_overflow = 1'b1;
			if (fill_count == 64)
				compress_block();
		end
		if (!it.end_of_message)
			return;
		if (len_overflow) begin
			r = '0;
			r.last_word = 1'b1;
			r.length_overflow = 1'b1;
			digest_queue.push_back(r);
			restart_hash();
			return;
		end
		// Padding: the marker byte, zeros, then the 64-bit length at the tail.
		msg_block[fill_count] = PAD_BYTE;
		fill_count++;
		if (fill_count > 56) begin
			while (fill_count < 64) begin
				msg_block[fill_count] = 8'h00;
				fill_count++;
			end
			compress_block();
		end
		while (fill_count < 56) begin
			msg_block[fill_count] = 8'h00;
			fill_count++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[56+i] = msg_bits[63-8*i -: 8];
		compress_block();
		for (int n = 0; n < WORD_COUNT; n++) begin
			r.digest_word = chain[n];
			r.word_number = 3'(n);
			r.last_word = (n == WORD_COUNT - 1);
			r.length_overflow = 1'b0;
			digest_queue.push_back(r);
		end
		restart_hash();
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Sends one item: optional idle cycles, then push held until the transfer happens.
	// Called and returns at a falling edge.
	task automatic send_item(logic [7:0] data, logic has, logic eom);
		in_item_t it;
		it.data_byte = data;
		it.has_byte = has;
		it.end_of_message = eom;
		while ($urandom_range(99) < snd_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (full);
		predict_digest(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Sends a whole message of random bytes; the end rides on the last byte or stands alone.
	task automatic send_message(int len);
		logic split_end;
		split_end = (len == 0) || $urandom_range(1);
		for (int i = 0; i < len; i++) begin
			// Now and then a step with no byte, which the hasher ignores.
			if ($urandom_range(19) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, (i == len - 1) && !split_end);
		end
		if (split_end)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Message lengths around the padding and block edges are favored.
	function automatic int pick_length();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0: begin
				return $urandom_range(3);
			end
			1, 2: begin
				return 54 + $urandom_range(3);
			end
			3: begin
				return 63 + $urandom_range(2);
			end
			4: begin
				return 118 + $urandom_range(3);
			end
			default: begin
				return $urandom_range(20);
			end
		endcase
	endfunction

	// The receiver pops at random, at the falling edge.
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Every result transfer is checked against the oldest prediction, field by field.
	// The watchdog counts cycles in which no transfer happens on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
			if (pop && !empty) begin
				if (digest_queue.size() == 0) begin
					report_mismatch("unexpected result", out_item.digest_word, 32'h0);
				end else begin
					out_item_t want;
					want = digest_queue.pop_front();
					if (out_item.digest_word !== want.digest_word)
						report_mismatch("digest_word", out_item.digest_word,
							want.digest_word);
					if (out_item.word_number !== want.word_number)
						report_mismatch("word_number", 32'(out_item.word_number),
							32'(want.word_number));
					if (out_item.last_word !== want.last_word)
						report_mismatch("last_word", 32'(out_item.last_word),
							32'(want.last_word));
					if (out_item.length_overflow !== want.length_overflow)
						report_mismatch("length_overflow", 32'(out_item.length_overflow),
							32'(want.length_overflow));
				end
			end
		end
	end

	// Empty messages, extreme bytes, ignored steps and an end without a byte.
	task automatic test_directed();
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b1);
	endtask

	// Random messages until the phase has sent its share of items.
	task automatic test_random_messages(int snd_pct, int rcv_pct, int item_goal);
		int start;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		start = items_sent;
		while (items_sent - start < item_goal)
			send_message(pick_length());
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		snd_idle_pct = 16;
		rcv_idle_pct = 82;
		error_count = 0;
		items_sent = 0;
		stall_cycles = 0;
		for (int i = 0; i < 64; i++)
			msg_block[i] = 8'h00;
		restart_hash();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_messages(16, 82, 90);
		test_random_messages(82, 16, 90);
		test_random_messages(0, 0, 100);
		push <= 1'b0;

		// Let every predicted result drain, then allow the engine to settle.
		while (digest_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
